// ----- sv/efra_pkg.sv -----
// ----------------------------------------------------------------------------
// efra_pkg
// Shared constants, state type and control structs of the room allocator.
// ----------------------------------------------------------------------------
package efra_pkg;

  localparam int unsigned MaxRooms = 16;
  localparam int unsigned IdxW     = (MaxRooms > 1) ? $clog2(MaxRooms) : 1;
  localparam int unsigned CntW     = $clog2(MaxRooms + 1);
  localparam int unsigned RoomW    = 7;
  localparam int unsigned TimeW    = 32;
  localparam int unsigned EndW     = 48;
  localparam int unsigned BookW    = 32;
  localparam int unsigned CfgW     = 8;
  localparam logic [CfgW-1:0] RoomCountReset = CfgW'(16);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_UPDATE
  } state_e;

  typedef struct packed {
    logic accept;
    logic issue;
    logic update;
  } ctrl_cmd_t;

  typedef struct packed {
    logic last_issue;
  } dp_status_t;

endpackage

// ----- sv/earliest_free_room_allocator_unit.sv -----
// ----------------------------------------------------------------------------
// earliest_free_room_allocator_unit
// Meeting room allocator: lowest free room, else earliest-releasing room.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low. The room table is
// scanned through one memory read port, one room per cycle, over the rooms
// in use (room_count clamped to 1..16), then a drain and an update state
// follow before the result is registered; busy stays high throughout.
// The result stands on the outputs for exactly one cycle while
// result_valid_o is high and must be captured then; the receiver cannot
// stall it. Write the room count only while busy is low.
module earliest_free_room_allocator_unit (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start,
  output logic                         busy,
  input  logic                         cfg_we_i,
  input  logic [efra_pkg::CfgW-1:0]    cfg_data_i,
  input  logic [efra_pkg::TimeW-1:0]   start_time_i,
  input  logic [efra_pkg::TimeW-1:0]   end_time_i,
  input  logic                         new_batch_i,
  output logic                         result_valid_o,
  output logic [efra_pkg::RoomW-1:0]   room_assigned_o,
  output logic [efra_pkg::EndW-1:0]    actual_end_o,
  output logic                         was_delayed_o,
  output logic [efra_pkg::RoomW-1:0]   busiest_room_o,
  output logic [efra_pkg::BookW-1:0]   busiest_count_o,
  output logic                         order_error_o
);
  import efra_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;

  efra_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .busy     (busy),
    .status_i (status),
    .cmd_o    (cmd)
  );

  efra_datapath u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_data_i      (cfg_data_i),
    .start_time_i    (start_time_i),
    .end_time_i      (end_time_i),
    .new_batch_i     (new_batch_i),
    .cmd_i           (cmd),
    .status_o        (status),
    .result_valid_o  (result_valid_o),
    .room_assigned_o (room_assigned_o),
    .actual_end_o    (actual_end_o),
    .was_delayed_o   (was_delayed_o),
    .busiest_room_o  (busiest_room_o),
    .busiest_count_o (busiest_count_o),
    .order_error_o   (order_error_o)
  );

endmodule

// ----- sv/efra_ctrl.sv -----
// ----------------------------------------------------------------------------
// efra_ctrl
// Sequencer: accept a request, scan the room table, finish and report.
// ----------------------------------------------------------------------------
module efra_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  efra_pkg::dp_status_t status_i,
  output efra_pkg::ctrl_cmd_t  cmd_o
);
  import efra_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (start) state_d = S_SCAN;
      end
      S_SCAN: begin
        if (status_i.last_issue) state_d = S_DRAIN;
      end
      S_DRAIN:  state_d = S_UPDATE;
      S_UPDATE: state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    busy  = 1'b1;
    case (state_q)
      S_IDLE: begin
        busy         = 1'b0;
        cmd_o.accept = start;
      end
      S_SCAN:   cmd_o.issue  = 1'b1;
      S_DRAIN:  ;
      S_UPDATE: cmd_o.update = 1'b1;
      default:  ;
    endcase
  end

endmodule

// ----- sv/efra_datapath.sv -----
// ----------------------------------------------------------------------------
// efra_datapath
// Room table, scan evaluation, booking update and result registers.
// ----------------------------------------------------------------------------
module efra_datapath (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [efra_pkg::CfgW-1:0]    cfg_data_i,
  input  logic [efra_pkg::TimeW-1:0]   start_time_i,
  input  logic [efra_pkg::TimeW-1:0]   end_time_i,
  input  logic                         new_batch_i,
  input  efra_pkg::ctrl_cmd_t          cmd_i,
  output efra_pkg::dp_status_t         status_o,
  output logic                         result_valid_o,
  output logic [efra_pkg::RoomW-1:0]   room_assigned_o,
  output logic [efra_pkg::EndW-1:0]    actual_end_o,
  output logic                         was_delayed_o,
  output logic [efra_pkg::RoomW-1:0]   busiest_room_o,
  output logic [efra_pkg::BookW-1:0]   busiest_count_o,
  output logic                         order_error_o
);
  import efra_pkg::*;

  localparam logic [EndW-1:0]  EndMax   = '1;
  localparam logic [BookW-1:0] CountMax = '1;

  // room table: release time over booking count
  logic [EndW+BookW-1:0] mem [MaxRooms];
  logic [MaxRooms-1:0]   valid_q;

  logic [CfgW-1:0]  room_count_q;
  logic [CntW-1:0]  used;
  logic [CntW-1:0]  rd_cnt_q;
  logic [IdxW-1:0]  rd_idx;

  logic [EndW+BookW-1:0] rd_data_q;
  logic                  rd_valid_q;
  logic                  eval_q;
  logic [IdxW-1:0]       eval_idx_q;

  logic [TimeW-1:0] start_q, end_q, dur_q, prev_start_q;
  logic             order_q;

  logic             found_q;
  logic [IdxW-1:0]  pick_q, early_q;
  logic [BookW-1:0] pick_cnt_q, early_cnt_q;
  logic [EndW-1:0]  early_rel_q;

  logic [IdxW-1:0]  best_room_q;
  logic [BookW-1:0] best_count_q;

  logic [EndW-1:0]  rel;
  logic [BookW-1:0] cnt;

  logic [IdxW-1:0]  sel;
  logic [EndW:0]    sum;
  logic [EndW-1:0]  fin;
  logic [BookW-1:0] sel_cnt, new_cnt;
  logic [IdxW-1:0]  best_room_d;
  logic [BookW-1:0] best_count_d;

  // clamp the room count into 1..MaxRooms
  always_comb begin
    if (room_count_q == '0) begin
      used = CntW'(1);
    end else if (room_count_q > CfgW'(MaxRooms)) begin
      used = CntW'(MaxRooms);
    end else begin
      used = CntW'(room_count_q);
    end
  end

  assign rd_idx              = rd_cnt_q[IdxW-1:0];
  assign status_o.last_issue = (rd_cnt_q == used - CntW'(1));

  // an entry never written since reset or batch reads as zero
  assign rel = rd_valid_q ? rd_data_q[EndW+BookW-1:BookW] : '0;
  assign cnt = rd_valid_q ? rd_data_q[BookW-1:0] : '0;

  always_comb begin
    sel     = found_q ? pick_q : early_q;
    sel_cnt = found_q ? pick_cnt_q : early_cnt_q;
    sum     = {1'b0, early_rel_q} + (EndW+1)'(dur_q);
    if (found_q) begin
      fin = EndW'(end_q);
    end else begin
      fin = sum[EndW] ? EndMax : sum[EndW-1:0];
    end
    new_cnt = (sel_cnt == CountMax) ? sel_cnt : sel_cnt + BookW'(1);
    best_room_d  = best_room_q;
    best_count_d = best_count_q;
    if (new_cnt > best_count_q) begin
      best_count_d = new_cnt;
      best_room_d  = sel;
    end else if (new_cnt == best_count_q && sel < best_room_q) begin
      best_room_d = sel;
    end
  end

  // table storage, no reset
  always_ff @(posedge clk_i) begin
    if (cmd_i.update) mem[sel] <= {fin, new_cnt};
    if (cmd_i.issue)  rd_data_q <= mem[rd_idx];
  end

  // request payload and scan candidates, no reset
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      start_q <= start_time_i;
      end_q   <= end_time_i;
      dur_q   <= (end_time_i > start_time_i) ? end_time_i - start_time_i : '0;
    end
    if (eval_q) begin
      if (eval_idx_q == '0 || rel < early_rel_q) begin
        early_q     <= eval_idx_q;
        early_rel_q <= rel;
        early_cnt_q <= cnt;
      end
      if (!found_q && rel <= EndW'(start_q)) begin
        pick_q     <= eval_idx_q;
        pick_cnt_q <= cnt;
      end
    end
    if (cmd_i.update) begin
      room_assigned_o <= RoomW'(sel);
      actual_end_o    <= fin;
      was_delayed_o   <= !found_q;
      busiest_room_o  <= RoomW'(best_room_d);
      busiest_count_o <= best_count_d;
      order_error_o   <= order_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      room_count_q   <= RoomCountReset;
      valid_q        <= '0;
      rd_cnt_q       <= '0;
      rd_valid_q     <= 1'b0;
      eval_q         <= 1'b0;
      eval_idx_q     <= '0;
      found_q        <= 1'b0;
      order_q        <= 1'b0;
      prev_start_q   <= '0;
      best_room_q    <= '0;
      best_count_q   <= '0;
      result_valid_o <= 1'b0;
    end else begin
      if (cfg_we_i) room_count_q <= cfg_data_i;
      eval_q         <= cmd_i.issue;
      result_valid_o <= cmd_i.update;
      if (cmd_i.accept) begin
        rd_cnt_q     <= '0;
        found_q      <= 1'b0;
        prev_start_q <= start_time_i;
        if (new_batch_i) begin
          // drop all bookings before this request
          valid_q      <= '0;
          best_room_q  <= '0;
          best_count_q <= '0;
          order_q      <= 1'b0;
        end else begin
          order_q <= (start_time_i < prev_start_q);
        end
      end
      if (cmd_i.issue) begin
        rd_cnt_q   <= rd_cnt_q + CntW'(1);
        rd_valid_q <= valid_q[rd_idx];
        eval_idx_q <= rd_idx;
      end
      if (eval_q && !found_q && rel <= EndW'(start_q)) found_q <= 1'b1;
      if (cmd_i.update) begin
        valid_q[sel] <= 1'b1;
        best_room_q  <= best_room_d;
        best_count_q <= best_count_d;
      end
    end
  end

endmodule

// ----- sv/efra_checker.sv -----
// ----------------------------------------------------------------------------
// efra_checker
// Port-level checks on the allocator's transfer and result timing, room range and end width.
// ----------------------------------------------------------------------------
module efra_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         start,
  input logic                         busy,
  input logic                         result_valid_o,
  input logic [efra_pkg::RoomW-1:0]   room_assigned_o,
  input logic [efra_pkg::EndW-1:0]    actual_end_o,
  input logic                         was_delayed_o,
  input logic [efra_pkg::RoomW-1:0]   busiest_room_o
);
  import efra_pkg::*;

  // a transfer always starts work
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("transfer did not raise busy");

  // result strobe is one cycle wide
  a_strobe_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !result_valid_o)
    else $error("result strobe longer than one cycle");

  a_strobe_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> !busy)
    else $error("result shown while still busy");

  a_room_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> (room_assigned_o < RoomW'(MaxRooms) &&
                        busiest_room_o < RoomW'(MaxRooms)))
    else $error("room index beyond table");

  // an undelayed meeting's end fits in the 32-bit input time range
  a_free_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && !was_delayed_o) |-> (actual_end_o[EndW-1:TimeW] == '0))
    else $error("undelayed end wider than input time");

endmodule

bind earliest_free_room_allocator_unit efra_checker u_efra_checker (.*);

// ----- tb/earliest_free_room_allocator_unit_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// earliest_free_room_allocator_unit_tb
// Self-checking bench for the meeting room allocator. Requests are sent one
// per transfer and each result is compared field by field with a bit-exact
// predictor kept in the bench. Directed tests cover the extremes, delays,
// ties, order errors, room count limits and long postponements; random phases
// then run well-formed schedules mixed with noise under several room counts.
// ----------------------------------------------------------------------------
module earliest_free_room_allocator_unit_tb;
  import efra_pkg::*;

  localparam int unsigned StallLimit = 2000;
  localparam logic [EndW-1:0] EndMax = '1;
  localparam logic [BookW-1:0] BookMax = '1;
  localparam int unsigned RandomItems = 860;

  typedef struct {
    logic [RoomW-1:0] room;
    logic [EndW-1:0]  fin;
    logic             delayed;
    logic [RoomW-1:0] top_room;
    logic [BookW-1:0] top_count;
    logic             order_err;
  } booking_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                start = 1'b0;
  logic                busy;
  logic                cfg_we_i = 1'b0;
  logic [CfgW-1:0]     cfg_data_i = '0;
  logic [TimeW-1:0]    start_time_i = '0;
  logic [TimeW-1:0]    end_time_i = '0;
  logic                new_batch_i = 1'b0;
  logic                result_valid_o;
  logic [RoomW-1:0]    room_assigned_o;
  logic [EndW-1:0]     actual_end_o;
  logic                was_delayed_o;
  logic [RoomW-1:0]    busiest_room_o;
  logic [BookW-1:0]    busiest_count_o;
  logic                order_error_o;

  // predictor state
  logic [EndW-1:0]     rel_time [MaxRooms];
  logic [BookW-1:0]    book_cnt [MaxRooms];
  logic [RoomW-1:0]    top_room;
  logic [BookW-1:0]    top_count;
  logic [TimeW-1:0]    last_start;
  logic [CfgW-1:0]     rooms_cfg;

  booking_t            booking_q[$];
  int unsigned         mismatch_count = 0;
  int unsigned         stall_cycles = 0;

  earliest_free_room_allocator_unit u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start           (start),
    .busy            (busy),
    .cfg_we_i        (cfg_we_i),
    .cfg_data_i      (cfg_data_i),
    .start_time_i    (start_time_i),
    .end_time_i      (end_time_i),
    .new_batch_i     (new_batch_i),
    .result_valid_o  (result_valid_o),
    .room_assigned_o (room_assigned_o),
    .actual_end_o    (actual_end_o),
    .was_delayed_o   (was_delayed_o),
    .busiest_room_o  (busiest_room_o),
    .busiest_count_o (busiest_count_o),
    .order_error_o   (order_error_o)
  );

  always #10 clk_i = ~clk_i;

  function automatic void clear_schedule();
    for (int k = 0; k < MaxRooms; k++) begin
      rel_time[k] = '0;
      book_cnt[k] = '0;
    end
    top_room   = '0;
    top_count  = '0;
    last_start = '0;
  endfunction

  function automatic booking_t predict_booking(logic [TimeW-1:0] st, logic [TimeW-1:0] en,
                                               logic nb);
    booking_t        r;
    int              used;
    int              pick;
    int              early;
    bit              found;
    logic [TimeW-1:0] dur;
    logic [EndW:0]   sum;
    used  = rooms_cfg;
    pick  = 0;
    early = 0;
    found = 1'b0;
    if (used < 1) used = 1;
    if (used > MaxRooms) used = MaxRooms;
    if (nb) clear_schedule();
    r.order_err = (st < last_start);
    last_start  = st;
    dur = (en > st) ? en - st : '0;
    for (int k = 0; k < used; k++) begin
      if (!found && rel_time[k] <= {16'b0, st}) begin
        pick  = k;
        found = 1'b1;
      end
      if (rel_time[k] < rel_time[early]) early = k;
    end
    if (found) begin
      r.fin     = {16'b0, en};
      r.delayed = 1'b0;
    end else begin
      pick      = early;
      r.delayed = 1'b1;
      sum       = {1'b0, rel_time[pick]} + {17'b0, dur};
      r.fin     = sum[EndW] ? EndMax : sum[EndW-1:0];
    end
    rel_time[pick] = r.fin;
    if (book_cnt[pick] != BookMax) book_cnt[pick] = book_cnt[pick] + 1'b1;
    if (book_cnt[pick] > top_count) begin
      top_count = book_cnt[pick];
      top_room  = RoomW'(pick);
    end else if (book_cnt[pick] == top_count && RoomW'(pick) < top_room) begin
      top_room = RoomW'(pick);
    end
    r.room      = RoomW'(pick);
    r.top_room  = top_room;
    r.top_count = top_count;
    return r;
  endfunction

  // Call only right after a rising edge. Start stays high on return.
  task automatic send_request(logic [TimeW-1:0] st, logic [TimeW-1:0] en, logic nb);
    start        <= 1'b1;
    start_time_i <= st;
    end_time_i   <= en;
    new_batch_i  <= nb;
    do @(posedge clk_i); while (busy);
    booking_q.push_back(predict_booking(st, en, nb));
  endtask

  task automatic rest_sender(int unsigned n);
    start <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  task automatic write_room_count(logic [CfgW-1:0] v);
    start <= 1'b0;
    do @(posedge clk_i); while (booking_q.size() != 0 || busy);
    cfg_we_i   <= 1'b1;
    cfg_data_i <= v;
    @(posedge clk_i);
    rooms_cfg = v;
    cfg_we_i   <= 1'b0;
  endtask

  task automatic check_field(string what, logic [EndW-1:0] exp_v, logic [EndW-1:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, what, exp_v, act_v);
      mismatch_count++;
    end
  endtask

  always @(posedge clk_i) begin
    booking_t b;
    if (rst_ni && result_valid_o) begin
      if (booking_q.size() == 0) begin
        $display("%0t: result with no request pending, expected none actual room %0h",
                 $time, room_assigned_o);
        mismatch_count++;
      end else begin
        b = booking_q.pop_front();
        check_field("room_assigned", EndW'(b.room), EndW'(room_assigned_o));
        check_field("actual_end", b.fin, actual_end_o);
        check_field("was_delayed", EndW'(b.delayed), EndW'(was_delayed_o));
        check_field("busiest_room", EndW'(b.top_room), EndW'(busiest_room_o));
        check_field("busiest_count", EndW'(b.top_count), EndW'(busiest_count_o));
        check_field("order_error", EndW'(b.order_err), EndW'(order_error_o));
      end
    end
  end

  // Watchdog: end the run when nothing transfers for too long.
  always @(posedge clk_i) begin
    if ((start && !busy) || (rst_ni && result_valid_o)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= StallLimit) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  task automatic test_first_request();
    send_request(32'd100, 32'd200, 1'b0);
  endtask

  task automatic test_field_extremes();
    send_request(32'd50, 32'd60, 1'b0);             // start below previous
    send_request(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
    send_request(32'd0, 32'hFFFF_FFFF, 1'b1);
    send_request(32'hFFFF_FFFF, 32'd0, 1'b0);       // end below start
  endtask

  task automatic test_delay_and_ties();
    write_room_count(8'd2);
    send_request(32'd10, 32'd20, 1'b1);
    send_request(32'd10, 32'd30, 1'b0);
    send_request(32'd10, 32'd15, 1'b0);             // all busy, postpone
    send_request(32'd12, 32'd12, 1'b0);             // postponed, zero length
    send_request(32'd40, 32'd50, 1'b0);
    send_request(32'd40, 32'd45, 1'b0);
    send_request(32'd0, 32'd100, 1'b1);
    send_request(32'd0, 32'd100, 1'b0);
    send_request(32'd5, 32'd10, 1'b0);              // equal release times
  endtask

  task automatic test_room_count_range();
    write_room_count(8'd0);
    send_request(32'd0, 32'd5, 1'b1);
    send_request(32'd1, 32'd3, 1'b0);
    write_room_count(8'd255);
    for (int i = 0; i < MaxRooms + 1; i++) send_request(32'd0, 32'd1000, i == 0);
    write_room_count(8'd1);
    send_request(32'd2000, 32'd2100, 1'b0);
    write_room_count(8'd16);
    send_request(32'd1500, 32'd1600, 1'b0);         // rooms 1..15 kept their state
  endtask

  // One room, full-length meetings all at time zero: every postponement
  // pushes the release further, well past the 32-bit input range.
  task automatic test_long_postponement();
    write_room_count(8'd1);
    send_request(32'd0, 32'hFFFF_FFFF, 1'b1);
    for (int i = 0; i < 40; i++) send_request(32'd0, 32'hFFFF_FFFF, 1'b0);
  endtask

  task automatic test_random_phases();
    int unsigned      sent;
    int unsigned      kind;
    int unsigned      gap_max;
    int unsigned      dur_max;
    int unsigned      phase_len;
    bit               idle_on;
    bit               last_phase;
    logic [TimeW-1:0] t;
    logic [TimeW-1:0] st;
    logic [TimeW-1:0] en;
    logic             nb;
    logic [CfgW-1:0]  rc;
    sent = 0;
    while (sent < RandomItems) begin
      kind = $urandom_range(0, 9);
      if (kind == 0) rc = 8'($urandom_range(17, 255));
      else if (kind == 1) rc = 8'd0;
      else if (kind == 2) rc = 8'd128;
      else rc = 8'($urandom_range(1, MaxRooms));
      write_room_count(rc);
      phase_len  = $urandom_range(30, 80);
      last_phase = (sent + phase_len >= RandomItems - 120);
      idle_on    = !last_phase && ($urandom_range(0, 2) != 0);
      gap_max    = $urandom_range(1, 30);
      dur_max    = $urandom_range(1, 200);
      kind       = $urandom_range(0, 9);
      if (kind < 6) t = $urandom_range(0, 1000);
      else if (kind < 8) t = 32'hFFFF_F000 + $urandom_range(0, 2048);
      else t = $urandom;
      for (int i = 0; i < phase_len; i++) begin
        kind = $urandom_range(0, 99);
        nb   = (i == 0) ? ($urandom_range(0, 3) != 0) : ($urandom_range(0, 99) == 0);
        if (kind < 8) begin
          st = $urandom;
          en = $urandom;
          nb = $urandom_range(0, 1);
        end else if (kind < 13) begin
          st = t - $urandom_range(1, 50);
          en = st + $urandom_range(1, dur_max);
        end else if (kind < 19) begin
          t  = t + $urandom_range(0, gap_max);
          st = t;
          en = st - $urandom_range(0, 5);
        end else begin
          t  = t + $urandom_range(0, gap_max);
          st = t;
          en = st + $urandom_range(1, dur_max);
        end
        if (idle_on && $urandom_range(0, 3) == 0) rest_sender($urandom_range(1, 10));
        send_request(st, en, nb);
        sent++;
      end
    end
  endtask

  initial begin
    clear_schedule();
    rooms_cfg = RoomCountReset;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_first_request();
    test_field_extremes();
    test_delay_and_ties();
    test_room_count_range();
    test_long_postponement();
    test_random_phases();
    start <= 1'b0;
    while (booking_q.size() != 0) @(posedge clk_i);
    repeat (25) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ----- files.f -----
sv/efra_pkg.sv
sv/efra_ctrl.sv
sv/efra_datapath.sv
sv/earliest_free_room_allocator_unit.sv
sv/efra_checker.sv
tb/earliest_free_room_allocator_unit_tb.sv
